/* rtl/core/boyer_moore_search_macros.svh */
// Assertion macros shared by the boyer_moore_search RTL.
// Needs clk and rst_n in the scope of each use.
`ifndef BOYER_MOORE_SEARCH_MACROS_SVH
`define BOYER_MOORE_SEARCH_MACROS_SVH

// Same-cycle implication, disabled during reset
`define BMS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define BMS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/bms_pkg.sv */
// Shared constants, codes and controller/datapath bundles for boyer_moore_search.
// No dependencies.
package bms_pkg;

    localparam int PATTERN_MAX = 32;
    localparam int TEXT_MAX    = 1024;
    localparam int BYTE_W      = 8;
    localparam int ALPHA       = 256;
    localparam int ALPHA_W     = $clog2(ALPHA);
    localparam int PAT_AW      = $clog2(PATTERN_MAX);
    localparam int TXT_AW      = $clog2(TEXT_MAX);
    localparam int PLEN_W      = $clog2(PATTERN_MAX + 1);
    localparam int TLEN_W      = $clog2(TEXT_MAX + 1);
    localparam int LO_W        = PLEN_W;
    localparam int POS_W       = 10;

    // Byte kinds carried by the op field
    localparam logic OP_PATTERN = 1'b0;
    localparam logic OP_TEXT    = 1'b1;

    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_OVERFLOW  = 2'd2
    } status_t;

    typedef struct packed {
        logic    accept;
        logic    init;
        logic    clr_step;
        logic    fill_sel;
        logic    fill_wr;
        logic    step_i;
        logic    shift;
        logic    load_out;
        status_t code;
    } cmd_t;

    typedef struct packed {
        logic ovf_any;
        logic n_gt_m;
        logic n_zero;
        logic k_last_clr;
        logic k_last_fill;
        logic equal;
        logic i_zero;
        logic past;
        logic out_free;
    } sts_t;

endpackage

/* rtl/core/bms_in_if.sv */
// Input byte channel: valid/ready handshake with op, data and last.
// Depends on bms_pkg.
interface bms_in_if;
    logic                        valid;
    logic                        ready;
    logic                        op;
    logic [bms_pkg::BYTE_W-1:0]  data;
    logic                        last;

    modport source (output valid, output op, output data, output last, input ready);
    modport sink   (input valid, input op, input data, input last, output ready);
endinterface

/* rtl/core/bms_out_if.sv */
// Result channel: valid/ready handshake with status and position.
// Depends on bms_pkg.
interface bms_out_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 status;
    logic [bms_pkg::POS_W-1:0]  position;

    modport source (output valid, output status, output position, input ready);
    modport sink   (input valid, input status, input position, output ready);
endinterface

/* rtl/core/bms_ram.sv */
// Generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
module bms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/bms_dp.sv */
// Datapath: byte stores, last-occurrence table, counters and result register.
// Depends on bms_pkg and bms_ram.
module bms_dp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  bms_pkg::cmd_t              cmd,
    output bms_pkg::sts_t              sts,
    input  logic                       op,
    input  logic [bms_pkg::BYTE_W-1:0] data,
    input  logic                       last,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [1:0]                 out_status,
    output logic [bms_pkg::POS_W-1:0]  out_position
);

    logic [bms_pkg::PLEN_W-1:0]  plen_reg;
    logic                        closed_reg;
    logic                        povf_reg;
    logic [bms_pkg::TLEN_W-1:0]  tlen_reg;
    logic                        tovf_reg;
    logic [bms_pkg::ALPHA_W-1:0] k_reg;
    logic [bms_pkg::PAT_AW-1:0]  i_reg;
    logic [bms_pkg::TLEN_W-1:0]  s_reg;
    logic                        out_valid_reg;
    logic [1:0]                  out_status_reg;
    logic [bms_pkg::POS_W-1:0]   out_pos_reg;

    logic [bms_pkg::PLEN_W-1:0]  plen_eff;
    logic                        pat_we;
    logic                        txt_we;
    logic [bms_pkg::PAT_AW-1:0]  pat_raddr;
    logic [bms_pkg::BYTE_W-1:0]  pat_rdata;
    logic [bms_pkg::TXT_AW-1:0]  txt_raddr;
    logic [bms_pkg::BYTE_W-1:0]  txt_rdata;
    logic                        lo_we;
    logic [bms_pkg::ALPHA_W-1:0] lo_waddr;
    logic [bms_pkg::LO_W-1:0]    lo_wdata;
    logic [bms_pkg::LO_W-1:0]    lo_rdata;
    logic [bms_pkg::PLEN_W-1:0]  i_plus1;
    logic [bms_pkg::PLEN_W-1:0]  shift_amt;
    logic [bms_pkg::TLEN_W:0]    s_new;
    logic [bms_pkg::TLEN_W+1:0]  s_end;
    logic [bms_pkg::PAT_AW-1:0]  i_start;

    // Load-side write enables
    assign plen_eff = closed_reg ? '0 : plen_reg;
    assign pat_we   = cmd.accept && (op == bms_pkg::OP_PATTERN)
                      && (plen_eff < bms_pkg::PLEN_W'(bms_pkg::PATTERN_MAX));
    assign txt_we   = cmd.accept && (op == bms_pkg::OP_TEXT)
                      && (tlen_reg < bms_pkg::TLEN_W'(bms_pkg::TEXT_MAX));

    // Read addresses
    assign pat_raddr = cmd.fill_sel ? k_reg[bms_pkg::PAT_AW-1:0] : i_reg;
    assign txt_raddr = s_reg[bms_pkg::TXT_AW-1:0] + bms_pkg::TXT_AW'(i_reg);

    // Last-occurrence table holds index + 1, zero means absent
    assign lo_we    = cmd.clr_step || cmd.fill_wr;
    assign lo_waddr = cmd.clr_step ? k_reg : pat_rdata;
    assign lo_wdata = cmd.clr_step ? '0
                                   : bms_pkg::LO_W'(k_reg[bms_pkg::PAT_AW-1:0]) + 1'b1;

    // Bad-character shift, at least one
    assign i_plus1   = bms_pkg::PLEN_W'(i_reg) + 1'b1;
    assign shift_amt = (i_plus1 > lo_rdata) ? (i_plus1 - lo_rdata) : bms_pkg::PLEN_W'(1);
    assign s_new     = (bms_pkg::TLEN_W+1)'(s_reg) + (bms_pkg::TLEN_W+1)'(shift_amt);
    assign s_end     = (bms_pkg::TLEN_W+2)'(s_new) + (bms_pkg::TLEN_W+2)'(plen_reg);
    assign i_start   = bms_pkg::PAT_AW'(plen_reg - 1'b1);

    bms_ram #(.WIDTH(bms_pkg::BYTE_W), .DEPTH(bms_pkg::PATTERN_MAX)) u_pat_ram (
        .clk   (clk),
        .we    (pat_we),
        .waddr (plen_eff[bms_pkg::PAT_AW-1:0]),
        .wdata (data),
        .raddr (pat_raddr),
        .rdata (pat_rdata)
    );

    bms_ram #(.WIDTH(bms_pkg::BYTE_W), .DEPTH(bms_pkg::TEXT_MAX)) u_txt_ram (
        .clk   (clk),
        .we    (txt_we),
        .waddr (tlen_reg[bms_pkg::TXT_AW-1:0]),
        .wdata (data),
        .raddr (txt_raddr),
        .rdata (txt_rdata)
    );

    bms_ram #(.WIDTH(bms_pkg::LO_W), .DEPTH(bms_pkg::ALPHA)) u_lo_ram (
        .clk   (clk),
        .we    (lo_we),
        .waddr (lo_waddr),
        .wdata (lo_wdata),
        .raddr (txt_rdata),
        .rdata (lo_rdata)
    );

    // Lengths and overflow flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg   <= '0;
            closed_reg <= 1'b0;
            povf_reg   <= 1'b0;
            tlen_reg   <= '0;
            tovf_reg   <= 1'b0;
        end
        else if (cmd.accept && (op == bms_pkg::OP_PATTERN))
        begin
            plen_reg   <= pat_we ? plen_eff + 1'b1 : plen_eff;
            povf_reg   <= (povf_reg && !closed_reg) || !pat_we;
            closed_reg <= last;
        end
        else if (cmd.accept)
        begin
            if (txt_we)
            begin
                tlen_reg <= tlen_reg + 1'b1;
            end
            else
            begin
                tovf_reg <= 1'b1;
            end
        end
        else if (cmd.load_out)
        begin
            tlen_reg <= '0;
            tovf_reg <= 1'b0;
        end
    end

    // Search counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= '0;
            i_reg <= '0;
            s_reg <= '0;
        end
        else if (cmd.init)
        begin
            k_reg <= '0;
            i_reg <= i_start;
            s_reg <= '0;
        end
        else if (cmd.clr_step || cmd.fill_wr)
        begin
            k_reg <= k_reg + 1'b1;
        end
        else if (cmd.step_i)
        begin
            i_reg <= i_reg - 1'b1;
        end
        else if (cmd.shift)
        begin
            s_reg <= s_new[bms_pkg::TLEN_W-1:0];
            i_reg <= i_start;
        end
    end

    // Result register, frees when the beat is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_status_reg <= cmd.code;
            out_pos_reg    <= (cmd.code == bms_pkg::ST_FOUND)
                              ? s_reg[bms_pkg::POS_W-1:0] : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_status   = out_status_reg;
    assign out_position = out_pos_reg;

    // Status to the controller
    assign sts.ovf_any     = tovf_reg || povf_reg;
    assign sts.n_gt_m      = bms_pkg::TLEN_W'(plen_reg) > tlen_reg;
    assign sts.n_zero      = (plen_reg == '0);
    assign sts.k_last_clr  = (k_reg == bms_pkg::ALPHA_W'(bms_pkg::ALPHA - 1));
    assign sts.k_last_fill = (k_reg == bms_pkg::ALPHA_W'(plen_reg) - 1'b1);
    assign sts.equal       = (pat_rdata == txt_rdata);
    assign sts.i_zero      = (i_reg == '0);
    assign sts.past        = s_end > (bms_pkg::TLEN_W+2)'(tlen_reg);
    assign sts.out_free    = !out_valid_reg || out_ready;

endmodule

/* rtl/core/bms_ctrl.sv */
// Controller: sequences loading, table build, skip search and result hand-off.
// Depends on bms_pkg.
module bms_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_op,
    input  logic          in_last,
    output logic          in_ready,
    input  bms_pkg::sts_t sts,
    output bms_pkg::cmd_t cmd
);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_START   = 9'b000000010,
        S_CLR     = 9'b000000100,
        S_FILL_RD = 9'b000001000,
        S_FILL_WR = 9'b000010000,
        S_CMP_RD  = 9'b000100000,
        S_CMP     = 9'b001000000,
        S_BC      = 9'b010000000,
        S_DONE    = 9'b100000000
    } state_t;

    state_t           state_reg, state_next;
    bms_pkg::status_t code_reg, code_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            code_reg  <= bms_pkg::ST_NOT_FOUND;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        cmd        = '0;
        cmd.code   = code_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.accept = in_valid;
                if (in_valid && (in_op == bms_pkg::OP_TEXT) && in_last)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                cmd.init = 1'b1;
                if (sts.ovf_any)
                begin
                    code_next  = bms_pkg::ST_OVERFLOW;
                    state_next = S_DONE;
                end
                else if (sts.n_gt_m)
                begin
                    code_next  = bms_pkg::ST_NOT_FOUND;
                    state_next = S_DONE;
                end
                else if (sts.n_zero)
                begin
                    code_next  = bms_pkg::ST_FOUND;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_CLR;
                end
            end
            S_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.k_last_clr)
                begin
                    state_next = S_FILL_RD;
                end
            end
            S_FILL_RD:
            begin
                cmd.fill_sel = 1'b1;
                state_next   = S_FILL_WR;
            end
            S_FILL_WR:
            begin
                cmd.fill_wr = 1'b1;
                state_next  = sts.k_last_fill ? S_CMP_RD : S_FILL_RD;
            end
            S_CMP_RD:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (!sts.equal)
                begin
                    state_next = S_BC;
                end
                else if (sts.i_zero)
                begin
                    code_next  = bms_pkg::ST_FOUND;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.step_i = 1'b1;
                    state_next = S_CMP_RD;
                end
            end
            S_BC:
            begin
                if (sts.past)
                begin
                    code_next  = bms_pkg::ST_NOT_FOUND;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.shift  = 1'b1;
                    state_next = S_CMP_RD;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/boyer_moore_search.sv */
// Boyer-Moore exact search. While idle, pattern and text bytes load at one beat per
// cycle. The text byte marked last starts a search: a check state that may end it at
// once, then a clear of all 256 last-occurrence entries, a read and a write per pattern
// byte to fill the table, then a read and a compare per compared byte and a bad-character
// step per skip, each bound by the registered read of the text and table memories. The
// result waits in an output register; new bytes are taken again as soon as it is loaded there.
// Depends on bms_pkg, bms_in_if, bms_out_if, bms_ctrl, bms_dp and the macro header.
`include "boyer_moore_search_macros.svh"

module boyer_moore_search (
    input  logic         clk,
    input  logic         rst_n,
    bms_in_if.sink       bytes,
    bms_out_if.source    result
);

    bms_pkg::cmd_t cmd;
    bms_pkg::sts_t sts;

    bms_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (bytes.valid),
        .in_op    (bytes.op),
        .in_last  (bytes.last),
        .in_ready (bytes.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bms_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .op           (bytes.op),
        .data         (bytes.data),
        .last         (bytes.last),
        .out_valid    (result.valid),
        .out_ready    (result.ready),
        .out_status   (result.status),
        .out_position (result.position)
    );

    // Checks
    `BMS_ASSERT_NOW(a_load_only_when_free, cmd.load_out, sts.out_free, "result loaded over a pending beat")
    `BMS_ASSERT_NEXT(a_load_shows_valid, cmd.load_out, result.valid, "loaded result not presented")
    `BMS_ASSERT_NOW(a_no_shift_past_end, cmd.shift, !sts.past, "shift beyond text end")

endmodule
